// ----- design/tdl_pkg.sv -----
package tdl_pkg;

	// One tap request as it arrives on the command channel.
	typedef struct packed {
		logic [15:0] on_ticks;
		logic [15:0] off_ticks;
		logic [1:0]  anode_driver;
		logic [3:0]  anode_pin;
		logic [1:0]  cathode_driver;
		logic [3:0]  cathode_pin;
		logic [31:0] now_us;
		logic [2:0]  overheat_level;
	} tdl_in_t;

	// One finished tap as it leaves on the result channel.
	typedef struct packed {
		logic        drive;
		logic [19:0] on_time_us;
		logic [22:0] off_time_us;
		logic        clamped;
		logic        overtap;
		logic [5:0]  anode_index;
		logic [5:0]  cathode_index;
	} tdl_out_t;

	// Field widths.
	localparam int ON_W   = 20;
	localparam int OFF_W  = 23;
	localparam int HEAT_W = 32;
	localparam int DIV_W  = 16;
	localparam int ACC_W  = 24;
	localparam int DRV_W  = 3;

	// Tick scaling of the request durations.
	localparam logic [ON_W-1:0]  ON_TICK_US  = 20'd10;
	localparam logic [OFF_W-1:0] OFF_TICK_US = 23'd100;

	// Configuration register indexes (byte address bits [4:2]).
	localparam logic [2:0] REG_MAX_ON     = 3'd0;
	localparam logic [2:0] REG_DRIVERS    = 3'd1;
	localparam logic [2:0] REG_COOL_DIV   = 3'd2;
	localparam logic [2:0] REG_ACC_HEAT   = 3'd3;
	localparam logic [2:0] REG_ATTEN_DIV  = 3'd4;
	localparam logic [2:0] REG_PROT_EN    = 3'd5;

	// Reset values of the configuration registers.
	localparam logic [ON_W-1:0]  MAX_ON_RST    = 20'd100000;
	localparam logic [DRV_W-1:0] DRIVERS_RST   = 3'd4;
	localparam logic [DIV_W-1:0] COOL_DIV_RST  = 16'd10;
	localparam logic [ACC_W-1:0] ACC_HEAT_RST  = 24'd100000;
	localparam logic [DIV_W-1:0] ATTEN_DIV_RST = 16'd10;

	// Board overheat levels that shorten the on time.
	localparam logic [2:0] OVH_MILD     = 3'd1;
	localparam logic [2:0] OVH_MODERATE = 3'd2;
	localparam logic [2:0] OVH_HIGH     = 3'd3;
	localparam logic [2:0] OVH_SEVERE   = 3'd4;

	// The divider retires two quotient bits per cycle over a 32-bit dividend.
	localparam int DIV_STEPS_W = 4;

endpackage

// ----- design/tap_thermal_duration_limiter.sv -----
// Tap duration limiter with per-pair heat protection.
//
// Command channel: drive req and raise start; the beat is taken at a clock edge
// where start is high and busy is low. Exactly one result beat follows on res,
// marked by done for a single cycle. The receiver cannot stall, so the result
// must be captured in that cycle.
// Configuration: APB-style registers at byte addresses 0x00 to 0x14, to be
// written only while the block is idle, which the block does not enforce.
// pready is tied high. A pause, an empty tap or a tap with protection off goes
// straight from accept to the finishing step; a protected tap reads the pair
// memories, runs a cooling division and writes back; a hot tap adds two more
// divisions and an attenuation step. The next request may be accepted in the
// cycle done is high. All divisions share one radix-4 divider, three at most.
// After reset the two pair memories are cleared one entry per cycle, all PAIRS
// entries (1600 with default parameters); busy stays high during that pass.
module tap_thermal_duration_limiter #(
	parameter int MAX_DRIVERS        = 4,
	parameter int OUTPUTS_PER_DRIVER = 10
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             psel,
	input  logic             penable,
	input  logic             pwrite,
	input  logic [4:0]       paddr,
	input  logic [31:0]      pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  logic             start,
	output logic             busy,
	input  tdl_pkg::tdl_in_t req,
	output logic             done,
	output tdl_pkg::tdl_out_t res
);

	import tdl_pkg::*;

	localparam int PAIR_DIM = MAX_DRIVERS * OUTPUTS_PER_DRIVER;
	localparam int PAIRS    = PAIR_DIM * PAIR_DIM;
	localparam int AW       = (PAIRS > 1) ? $clog2(PAIRS) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(PAIRS - 1);
	localparam logic [AW-1:0] PAIR_STRIDE = AW'(PAIR_DIM);
	localparam logic [4:0] PIN_LIMIT = 5'(OUTPUTS_PER_DRIVER);
	localparam logic [5:0] PIN_STRIDE = 6'(OUTPUTS_PER_DRIVER);
	localparam logic [DRV_W-1:0] DRV_LIMIT = DRV_W'(MAX_DRIVERS);

	typedef enum logic [9:0] {
		ST_CLEAR    = 10'b0000000001,
		ST_IDLE     = 10'b0000000010,
		ST_READ     = 10'b0000000100,
		ST_LOAD     = 10'b0000001000,
		ST_DIV_COOL = 10'b0000010000,
		ST_DIV_EXC  = 10'b0000100000,
		ST_DIV_ON   = 10'b0001000000,
		ST_ATTEN    = 10'b0010000000,
		ST_UPDATE   = 10'b0100000000,
		ST_FINISH   = 10'b1000000000
	} state_t;

	state_t state_q, state_d;

	// Configuration registers.
	logic [ON_W-1:0]   max_on_q;
	logic [DRV_W-1:0]  drivers_q;
	logic [DIV_W-1:0]  cool_div_q;
	logic [ACC_W-1:0]  acc_heat_q;
	logic [DIV_W-1:0]  atten_div_q;
	logic              prot_en_q;

	// Per-item working registers.
	logic [ON_W-1:0]   on_q;
	logic [OFF_W-1:0]  off_q;
	logic              drive_q;
	logic              clamped_q;
	logic              overtap_q;
	logic [5:0]        aidx_q;
	logic [5:0]        cidx_q;
	logic [2:0]        level_q;
	logic [HEAT_W-1:0] now_q;
	logic [AW-1:0]     k_q;
	logic [HEAT_W-1:0] heat_q;
	logic [HEAT_W-1:0] att_q;

	// Divider registers.
	logic [HEAT_W-1:0]      div_quo_q;
	logic [DIV_W-1:0]       div_rem_q;
	logic [DIV_W-1:0]       div_den_q;
	logic [DIV_STEPS_W-1:0] div_cnt_q;

	logic [AW-1:0]     clr_cnt_q;
	logic              done_q;
	tdl_out_t          res_q;

	// Memory ports.
	logic              mem_we;
	logic [AW-1:0]     mem_addr;
	logic [HEAT_W-1:0] heat_wdata;
	logic [HEAT_W-1:0] time_wdata;
	logic [HEAT_W-1:0] heat_rd;
	logic [HEAT_W-1:0] time_rd;

	logic accept;
	logic cfg_we;

	assign busy   = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;
	assign done   = done_q;
	assign res    = res_q;

	// Decode of the incoming request.
	logic [ON_W-1:0]  on_raw;
	logic [OFF_W-1:0] off_raw;
	logic             on_zero;
	logic             on_over;
	logic [ON_W-1:0]  on_clamped;
	logic             pins_ok;
	logic             drivers_ok;
	logic             tap_ok;
	logic [5:0]       aidx_in;
	logic [5:0]       cidx_in;
	logic [AW-1:0]    k_in;

	always_comb begin
		on_raw     = ON_W'(req.on_ticks) * ON_TICK_US;
		off_raw    = OFF_W'(req.off_ticks) * OFF_TICK_US;
		on_zero    = (req.on_ticks == '0);
		on_over    = (on_raw > max_on_q);
		on_clamped = on_over ? max_on_q : on_raw;
		pins_ok    = ({1'b0, req.anode_pin} < PIN_LIMIT) &&
			({1'b0, req.cathode_pin} < PIN_LIMIT);
		drivers_ok = ({1'b0, req.anode_driver} < drivers_q) &&
			({1'b0, req.cathode_driver} < drivers_q) &&
			({1'b0, req.anode_driver} < DRV_LIMIT) &&
			({1'b0, req.cathode_driver} < DRV_LIMIT);
		tap_ok     = pins_ok && drivers_ok;
		aidx_in    = 6'(req.anode_driver) * PIN_STRIDE + 6'(req.anode_pin);
		cidx_in    = 6'(req.cathode_driver) * PIN_STRIDE + 6'(req.cathode_pin);
		k_in       = AW'(aidx_in) * PAIR_STRIDE + AW'(cidx_in);
	end

	// Two restoring division steps per cycle.
	logic [DIV_W:0]    div_r1;
	logic              div_ge1;
	logic [DIV_W-1:0]  div_r1s;
	logic [DIV_W:0]    div_r2;
	logic              div_ge2;
	logic [DIV_W-1:0]  div_r2s;
	logic [HEAT_W-1:0] quo_n;
	logic              div_last;

	always_comb begin
		div_r1   = {div_rem_q, div_quo_q[HEAT_W-1]};
		div_ge1  = (div_r1 >= {1'b0, div_den_q});
		div_r1s  = div_ge1 ? DIV_W'(div_r1 - {1'b0, div_den_q}) : div_r1[DIV_W-1:0];
		div_r2   = {div_r1s, div_quo_q[HEAT_W-2]};
		div_ge2  = (div_r2 >= {1'b0, div_den_q});
		div_r2s  = div_ge2 ? DIV_W'(div_r2 - {1'b0, div_den_q}) : div_r2[DIV_W-1:0];
		quo_n    = {div_quo_q[HEAT_W-3:0], div_ge1, div_ge2};
		div_last = (div_cnt_q == '1);
	end

	// Divisors of zero act as one.
	logic [DIV_W-1:0] cool_den;
	logic [DIV_W-1:0] atten_den;

	assign cool_den  = (cool_div_q == '0) ? DIV_W'(1) : cool_div_q;
	assign atten_den = (atten_div_q == '0) ? DIV_W'(1) : atten_div_q;

	// Cooling result and the heat limit test.
	logic [HEAT_W-1:0] cooled;
	logic              hot;

	assign cooled = (heat_q > quo_n) ? heat_q - quo_n : '0;
	assign hot    = (cooled > HEAT_W'(acc_heat_q));

	// Heat update with saturation.
	logic [HEAT_W:0]   heat_sum;
	logic [HEAT_W-1:0] heat_new;

	assign heat_sum = {1'b0, heat_q} + (HEAT_W + 1)'(on_q);
	assign heat_new = heat_sum[HEAT_W] ? '1 : heat_sum[HEAT_W-1:0];

	// Overheat scaling of the final on time.
	logic [ON_W+1:0]  on_x3;
	logic [ON_W+2:0]  on_x7;
	logic [ON_W-1:0]  on_final;
	logic [ON_W-1:0]  on_cut;

	always_comb begin
		on_x3 = (ON_W + 2)'(on_q) * (ON_W + 2)'(3);
		on_x7 = (ON_W + 3)'(on_q) * (ON_W + 3)'(7);
		case (level_q)
			OVH_MILD: begin
				on_final = on_x3[ON_W+1:2];
				on_cut   = on_q >> 2;
			end
			OVH_MODERATE: begin
				on_final = on_q >> 1;
				on_cut   = on_q >> 1;
			end
			OVH_HIGH: begin
				on_final = on_q >> 2;
				on_cut   = on_x3[ON_W+1:2];
			end
			OVH_SEVERE: begin
				on_final = on_q >> 3;
				on_cut   = on_x7[ON_W+2:3];
			end
			default: begin
				on_final = on_q;
				on_cut   = '0;
			end
		endcase
	end

	// Memory port selection: clearing pass, or the current pair.
	always_comb begin
		mem_we     = (state_q == ST_CLEAR) || (state_q == ST_UPDATE);
		mem_addr   = (state_q == ST_CLEAR) ? clr_cnt_q : k_q;
		heat_wdata = (state_q == ST_CLEAR) ? '0 : heat_new;
		time_wdata = (state_q == ST_CLEAR) ? '0 : now_q;
	end

	tdl_ram #(
		.WIDTH (HEAT_W),
		.DEPTH (PAIRS)
	) u_heat_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (heat_wdata),
		.rdata (heat_rd)
	);

	tdl_ram #(
		.WIDTH (HEAT_W),
		.DEPTH (PAIRS)
	) u_time_ram (
		.clk   (clk),
		.we    (mem_we),
		.addr  (mem_addr),
		.wdata (time_wdata),
		.rdata (time_rd)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_cnt_q == LAST_ADDR) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					state_d = (!on_zero && tap_ok && prot_en_q) ? ST_READ : ST_FINISH;
				end
			end
			ST_READ: begin
				state_d = ST_LOAD;
			end
			ST_LOAD: begin
				state_d = ST_DIV_COOL;
			end
			ST_DIV_COOL: begin
				if (div_last) begin
					state_d = hot ? ST_DIV_EXC : ST_UPDATE;
				end
			end
			ST_DIV_EXC: begin
				if (div_last) begin
					state_d = ST_DIV_ON;
				end
			end
			ST_DIV_ON: begin
				if (div_last) begin
					state_d = ST_ATTEN;
				end
			end
			ST_ATTEN: begin
				state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Control state, clearing counter and result strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_CLEAR;
			clr_cnt_q <= '0;
			done_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= (state_q == ST_FINISH);
			if (state_q == ST_CLEAR) begin
				clr_cnt_q <= clr_cnt_q + AW'(1);
			end
		end
	end

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_on_q    <= MAX_ON_RST;
			drivers_q   <= DRIVERS_RST;
			cool_div_q  <= COOL_DIV_RST;
			acc_heat_q  <= ACC_HEAT_RST;
			atten_div_q <= ATTEN_DIV_RST;
			prot_en_q   <= 1'b1;
		end else if (cfg_we) begin
			case (paddr[4:2])
				REG_MAX_ON:    max_on_q    <= pwdata[ON_W-1:0];
				REG_DRIVERS:   drivers_q   <= pwdata[DRV_W-1:0];
				REG_COOL_DIV:  cool_div_q  <= pwdata[DIV_W-1:0];
				REG_ACC_HEAT:  acc_heat_q  <= pwdata[ACC_W-1:0];
				REG_ATTEN_DIV: atten_div_q <= pwdata[DIV_W-1:0];
				REG_PROT_EN:   prot_en_q   <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// Configuration read-back.
	always_comb begin
		case (paddr[4:2])
			REG_MAX_ON:    prdata = 32'(max_on_q);
			REG_DRIVERS:   prdata = 32'(drivers_q);
			REG_COOL_DIV:  prdata = 32'(cool_div_q);
			REG_ACC_HEAT:  prdata = 32'(acc_heat_q);
			REG_ATTEN_DIV: prdata = 32'(atten_div_q);
			REG_PROT_EN:   prdata = 32'(prot_en_q);
			default:       prdata = '0;
		endcase
	end

	// Datapath: request decode, divider, attenuation and result.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					level_q   <= req.overheat_level;
					now_q     <= req.now_us;
					k_q       <= k_in;
					overtap_q <= 1'b0;
					if (on_zero) begin
						on_q      <= '0;
						off_q     <= off_raw;
						drive_q   <= 1'b0;
						clamped_q <= 1'b0;
						aidx_q    <= '0;
						cidx_q    <= '0;
					end else if (!tap_ok) begin
						on_q      <= '0;
						off_q     <= off_raw + OFF_W'(on_clamped);
						drive_q   <= 1'b0;
						clamped_q <= on_over;
						aidx_q    <= '0;
						cidx_q    <= '0;
					end else begin
						on_q      <= on_clamped;
						off_q     <= off_raw;
						drive_q   <= 1'b1;
						clamped_q <= on_over;
						aidx_q    <= aidx_in;
						cidx_q    <= cidx_in;
					end
				end
			end
			ST_LOAD: begin
				heat_q    <= heat_rd;
				div_quo_q <= now_q - time_rd;
				div_rem_q <= '0;
				div_den_q <= cool_den;
				div_cnt_q <= '0;
			end
			ST_DIV_COOL: begin
				div_quo_q <= quo_n;
				div_rem_q <= div_r2s;
				div_cnt_q <= div_cnt_q + DIV_STEPS_W'(1);
				if (div_last) begin
					heat_q <= cooled;
					if (hot) begin
						overtap_q <= 1'b1;
						div_quo_q <= cooled - HEAT_W'(acc_heat_q);
						div_rem_q <= '0;
						div_den_q <= atten_den;
						div_cnt_q <= '0;
					end
				end
			end
			ST_DIV_EXC: begin
				div_quo_q <= quo_n;
				div_rem_q <= div_r2s;
				div_cnt_q <= div_cnt_q + DIV_STEPS_W'(1);
				if (div_last) begin
					att_q     <= quo_n;
					div_quo_q <= HEAT_W'(on_q);
					div_rem_q <= '0;
					div_cnt_q <= '0;
				end
			end
			ST_DIV_ON: begin
				div_quo_q <= quo_n;
				div_rem_q <= div_r2s;
				div_cnt_q <= div_cnt_q + DIV_STEPS_W'(1);
				if (div_last) begin
					on_q  <= (HEAT_W'(on_q) > att_q) ? on_q - att_q[ON_W-1:0] : '0;
					att_q <= quo_n;
				end
			end
			ST_ATTEN: begin
				on_q <= (HEAT_W'(on_q) > att_q) ? on_q - att_q[ON_W-1:0] : '0;
			end
			ST_FINISH: begin
				res_q.drive         <= drive_q;
				res_q.on_time_us    <= on_final;
				res_q.off_time_us   <= off_q + OFF_W'(on_cut);
				res_q.clamped       <= clamped_q;
				res_q.overtap       <= overtap_q;
				res_q.anode_index   <= aidx_q;
				res_q.cathode_index <= cidx_q;
			end
			default: begin
			end
		endcase
	end

`ifndef SYNTHESIS
	// A result beat only follows the finishing step.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_FINISH))
		else $error("result strobe without a finished item");

	// An accepted request keeps the block busy in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("block idle right after accepting a request");

	// A tap that is not driven carries no on time and no overtap flag.
	assert property (@(posedge clk) disable iff (!arst_n)
		done && !res.drive |-> res.on_time_us == '0 && !res.overtap)
		else $error("undriven tap with on time or overtap");

	// The final on time never exceeds the clamp.
	assert property (@(posedge clk) disable iff (!arst_n)
		done |-> res.on_time_us <= max_on_q)
		else $error("on time above the configured maximum");

	// The divider remainder stays below its divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV_COOL || state_q == ST_DIV_EXC || state_q == ST_DIV_ON)
		|-> div_rem_q < div_den_q)
		else $error("divider remainder out of range");
`endif

endmodule

// ----- design/tdl_ram.sv -----
module tdl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1600
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                        wdata,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Single port: write at addr, registered read of the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata_q <= mem_q[addr];
	end

	assign rdata = rdata_q;

endmodule

// ----- tb/tap_result_checker.sv -----
`timescale 1ns / 100ps

// Watches the register port and both beat channels of the tap limiter, keeps its
// own copy of the settings and of the per-pair heat table, and compares every
// result beat against the oldest predicted tap.
module tap_result_checker #(
	parameter int MAX_DRIVERS        = 4,
	parameter int OUTPUTS_PER_DRIVER = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [4:0]        paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	input  logic              start,
	input  logic              busy,
	input  tdl_pkg::tdl_in_t  req,
	input  logic              done,
	input  tdl_pkg::tdl_out_t res,
	output int                fail_count,
	output int                pending
);

	import tdl_pkg::*;

	localparam int PAIR_DIM = MAX_DRIVERS * OUTPUTS_PER_DRIVER;
	localparam int PAIRS    = PAIR_DIM * PAIR_DIM;

	// Shadow copy of the configuration registers.
	logic [ON_W-1:0]  cfg_max_on;
	logic [DRV_W-1:0] cfg_drivers;
	logic [DIV_W-1:0] cfg_cool_div;
	logic [ACC_W-1:0] cfg_acc_heat;
	logic [DIV_W-1:0] cfg_atten_div;
	logic             cfg_prot_en;

	// Heat and last tap time of every anode/cathode pair.
	logic [HEAT_W-1:0] heat_by_pair [PAIRS];
	logic [31:0]       stamp_by_pair [PAIRS];

	tdl_out_t expected_taps [$];

	// Works out the result of one tap and updates the pair table as the block would.
	function automatic tdl_out_t predict_tap(tdl_in_t tap);
		tdl_out_t    r;
		logic [63:0] on_us;
		logic [63:0] off_us;
		logic [63:0] heat;
		logic [63:0] drop;
		logic [63:0] share;
		logic [63:0] cut;
		logic [63:0] cdiv;
		logic [63:0] adiv;
		logic [31:0] interval;
		int          slot;
		r      = '0;
		on_us  = 64'(tap.on_ticks) * 10;
		off_us = 64'(tap.off_ticks) * 100;
		cut    = '0;
		if (on_us != 0) begin
			if (on_us > cfg_max_on) begin
				on_us     = 64'(cfg_max_on);
				r.clamped = 1'b1;
			end
			if (tap.anode_pin < OUTPUTS_PER_DRIVER && tap.cathode_pin < OUTPUTS_PER_DRIVER &&
			    tap.anode_driver < cfg_drivers && tap.cathode_driver < cfg_drivers &&
			    tap.anode_driver < MAX_DRIVERS && tap.cathode_driver < MAX_DRIVERS) begin
				r.drive         = 1'b1;
				r.anode_index   = 6'(tap.anode_driver * OUTPUTS_PER_DRIVER + tap.anode_pin);
				r.cathode_index = 6'(tap.cathode_driver * OUTPUTS_PER_DRIVER +
					tap.cathode_pin);
				if (cfg_prot_en) begin
					slot = r.anode_index * PAIR_DIM + r.cathode_index;
					cdiv = (cfg_cool_div == 0) ? 64'd1 : 64'(cfg_cool_div);
					adiv = (cfg_atten_div == 0) ? 64'd1 : 64'(cfg_atten_div);
					// The pair cools by the elapsed time over cdiv; time wraps with the clock.
					interval = tap.now_us - stamp_by_pair[slot];
					drop     = 64'(interval) / cdiv;
					heat     = (64'(heat_by_pair[slot]) > drop) ?
						64'(heat_by_pair[slot]) - drop : '0;
					// A hot pair loses part of its on time, both cuts from the clamped value.
					if (heat > cfg_acc_heat) begin
						drop      = (heat - cfg_acc_heat) / adiv;
						share     = on_us / adiv;
						on_us     = (on_us > drop) ? on_us - drop : 0;
						on_us     = (on_us > share) ? on_us - share : 0;
						r.overtap = 1'b1;
					end
					heat = heat + on_us;
					if (heat > 64'hFFFF_FFFF)
						heat = 64'hFFFF_FFFF;
					heat_by_pair[slot]  = heat[31:0];
					stamp_by_pair[slot] = tap.now_us;
				end
				// Board overheat moves part of the on time into the pause.
				case (tap.overheat_level)
					OVH_MILD: begin
						cut   = on_us / 4;
						on_us = on_us * 3 / 4;
					end
					OVH_MODERATE: begin
						cut   = on_us / 2;
						on_us = on_us / 2;
					end
					OVH_HIGH: begin
						cut   = on_us * 3 / 4;
						on_us = on_us / 4;
					end
					OVH_SEVERE: begin
						cut   = on_us * 7 / 8;
						on_us = on_us / 8;
					end
					default: ;
				endcase
				off_us = off_us + cut;
			end else begin
				// Empty tap: the on time only lengthens the pause.
				off_us = off_us + on_us;
				on_us  = 0;
			end
		end
		r.on_time_us  = on_us[ON_W-1:0];
		r.off_time_us = off_us[OFF_W-1:0];
		return r;
	endfunction

	function automatic int field_mismatch(string field, logic [31:0] want, logic [31:0] got);
		if (want !== got) begin
			$error("%s: expected %0d, actual %0d", field, want, got);
			return 1;
		end
		return 0;
	endfunction

	// Register writes, result beats and command beats, in that order at each edge.
	always @(posedge clk or negedge arst_n) begin
		tdl_out_t want;
		int       errs;
		if (!arst_n) begin
			cfg_max_on    = MAX_ON_RST;
			cfg_drivers   = DRIVERS_RST;
			cfg_cool_div  = COOL_DIV_RST;
			cfg_acc_heat  = ACC_HEAT_RST;
			cfg_atten_div = ATTEN_DIV_RST;
			cfg_prot_en   = 1'b1;
			for (int i = 0; i < PAIRS; i++) begin
				heat_by_pair[i]  = '0;
				stamp_by_pair[i] = '0;
			end
			expected_taps.delete();
			pending    <= 0;
			fail_count <= 0;
		end else begin
			errs = 0;
			if (psel && penable && pwrite && pready) begin
				case (paddr[4:2])
					REG_MAX_ON:    cfg_max_on    = pwdata[ON_W-1:0];
					REG_DRIVERS:   cfg_drivers   = pwdata[DRV_W-1:0];
					REG_COOL_DIV:  cfg_cool_div  = pwdata[DIV_W-1:0];
					REG_ACC_HEAT:  cfg_acc_heat  = pwdata[ACC_W-1:0];
					REG_ATTEN_DIV: cfg_atten_div = pwdata[DIV_W-1:0];
					REG_PROT_EN:   cfg_prot_en   = pwdata[0];
					default: ;
				endcase
			end
			if (done) begin
				if (expected_taps.size() == 0) begin
					$error("result beat with no tap waiting: %h", res);
					errs++;
				end else begin
					want = expected_taps.pop_front();
					errs += field_mismatch("drive", want.drive, res.drive);
					errs += field_mismatch("on_time_us", want.on_time_us, res.on_time_us);
					errs += field_mismatch("off_time_us", want.off_time_us, res.off_time_us);
					errs += field_mismatch("clamped", want.clamped, res.clamped);
					errs += field_mismatch("overtap", want.overtap, res.overtap);
					errs += field_mismatch("anode_index", want.anode_index, res.anode_index);
					errs += field_mismatch("cathode_index", want.cathode_index,
						res.cathode_index);
				end
			end
			if (start && !busy)
				expected_taps.push_back(predict_tap(req));
			pending    <= expected_taps.size();
			fail_count <= fail_count + errs;
		end
	end

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
	import tdl_pkg::*;

	localparam int MAX_DRIVERS        = 4;
	localparam int OUTPUTS_PER_DRIVER = 10;

	logic        clk     = 1'b0;
	logic        arst_n  = 1'b0;
	logic        psel    = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite  = 1'b0;
	logic [4:0]  paddr   = '0;
	logic [31:0] pwdata  = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        start   = 1'b0;
	logic        busy;
	tdl_in_t     req     = '0;
	logic        done;
	tdl_out_t    res;

	int          fail_count;
	int          pending;
	int          random_sent = 0;
	logic [31:0] tap_clock   = '0;

	localparam int RANDOM_TAPS = 1600;

	always #5 clk = ~clk;

	tap_thermal_duration_limiter #(
		.MAX_DRIVERS       (MAX_DRIVERS),
		.OUTPUTS_PER_DRIVER(OUTPUTS_PER_DRIVER)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.start  (start),
		.busy   (busy),
		.req    (req),
		.done   (done),
		.res    (res)
	);

	tap_result_checker #(
		.MAX_DRIVERS       (MAX_DRIVERS),
		.OUTPUTS_PER_DRIVER(OUTPUTS_PER_DRIVER)
	) tap_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.start     (start),
		.busy      (busy),
		.req       (req),
		.done      (done),
		.res       (res),
		.fail_count(fail_count),
		.pending   (pending)
	);

	function automatic tdl_in_t tap_req(logic [15:0] on_ticks, logic [15:0] off_ticks,
		logic [1:0] ad, logic [3:0] ap, logic [1:0] cd, logic [3:0] cp,
		logic [31:0] now_us, logic [2:0] level);
		tdl_in_t tap;
		tap.on_ticks       = on_ticks;
		tap.off_ticks      = off_ticks;
		tap.anode_driver   = ad;
		tap.anode_pin      = ap;
		tap.cathode_driver = cd;
		tap.cathode_pin    = cp;
		tap.now_us         = now_us;
		tap.overheat_level = level;
		return tap;
	endfunction

	// Mostly taps on a small set of pairs with time moving forward in small steps,
	// so that heat builds up; the rest is noise and jumps of the clock.
	function automatic tdl_in_t random_tap();
		tdl_in_t     tap;
		int unsigned pick;
		int unsigned size;
		tap.off_ticks      = 16'($urandom);
		tap.overheat_level = 3'($urandom);
		pick               = $urandom_range(99);
		if (pick < 6) begin
			tap.on_ticks       = 16'($urandom);
			tap.anode_driver   = 2'($urandom);
			tap.anode_pin      = 4'($urandom);
			tap.cathode_driver = 2'($urandom);
			tap.cathode_pin    = 4'($urandom);
			tap.now_us         = $urandom;
		end else begin
			if (pick < 9)
				tap_clock = tap_clock + $urandom;
			else
				tap_clock = tap_clock + $urandom_range(3000);
			tap.now_us = tap_clock;
			size       = $urandom_range(99);
			if (size < 6)
				tap.on_ticks = '0;
			else if (size < 16)
				tap.on_ticks = 16'($urandom);
			else if (size < 26)
				tap.on_ticks = 16'($urandom_range(1, 100));
			else
				tap.on_ticks = 16'($urandom_range(1, 12000));
			if ($urandom_range(99) < 88) begin
				tap.anode_driver   = 2'($urandom_range(1));
				tap.anode_pin      = 4'($urandom_range(2));
				tap.cathode_driver = 2'($urandom_range(1));
				tap.cathode_pin    = 4'($urandom_range(2));
			end else begin
				tap.anode_driver   = 2'($urandom);
				tap.anode_pin      = 4'($urandom);
				tap.cathode_driver = 2'($urandom);
				tap.cathode_pin    = 4'($urandom);
			end
		end
		return tap;
	endfunction

	// Offers one beat, maybe after a gap; returns when it is taken and busy drops.
	task automatic send_tap(tdl_in_t tap, int idle_pct);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
			while ($urandom_range(99) < idle_pct)
				@(posedge clk);
		end
		start <= 1'b1;
		req   <= tap;
		do
			@(posedge clk);
		while (busy);
	endtask

	// Stops sending and waits until every tap in flight has come back.
	task automatic drain_taps();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic reg_write(logic [2:0] index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do
			@(posedge clk);
		while (!pready);
	endtask

	task automatic apply_setting(logic [ON_W-1:0] max_on, logic [DRV_W-1:0] drivers,
		logic [DIV_W-1:0] cool_div, logic [ACC_W-1:0] acc_heat,
		logic [DIV_W-1:0] atten_div, logic prot_en);
		reg_write(REG_MAX_ON, 32'(max_on));
		reg_write(REG_DRIVERS, 32'(drivers));
		reg_write(REG_COOL_DIV, 32'(cool_div));
		reg_write(REG_ACC_HEAT, 32'(acc_heat));
		reg_write(REG_ATTEN_DIV, 32'(atten_div));
		reg_write(REG_PROT_EN, 32'(prot_en));
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// The first third of the random taps has rare gaps, the second frequent gaps,
	// the last none. Every so often the sender waits for all results.
	task automatic run_random(int count);
		int idle_pct;
		tap_clock = $urandom;
		for (int i = 0; i < count; i++) begin
			if (random_sent < RANDOM_TAPS / 3)
				idle_pct = 15;
			else if (random_sent < 2 * RANDOM_TAPS / 3)
				idle_pct = 71;
			else
				idle_pct = 0;
			send_tap(random_tap(), idle_pct);
			random_sent++;
			if (i % 150 == 149)
				drain_taps();
		end
		drain_taps();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed taps under the reset settings.
		send_tap(tap_req(16'd0, 16'hFFFF, 2'd1, 4'd2, 2'd3, 4'd4, 32'd0, 3'd0), 0);
		send_tap(tap_req(16'd0, 16'd0, 2'd0, 4'd0, 2'd0, 4'd0, 32'd0, OVH_SEVERE), 0);
		// The same pair three times in a row: clamped, then heating up into overtap.
		send_tap(tap_req(16'hFFFF, 16'd0, 2'd0, 4'd0, 2'd0, 4'd0, 32'd0, 3'd0), 0);
		send_tap(tap_req(16'hFFFF, 16'd1, 2'd0, 4'd0, 2'd0, 4'd0, 32'd1, 3'd0), 0);
		send_tap(tap_req(16'hFFFF, 16'd2, 2'd0, 4'd0, 2'd0, 4'd0, 32'd2, 3'd0), 0);
		// A hot pair with a tiny request is still driven, with no on time left.
		send_tap(tap_req(16'd1, 16'd3, 2'd0, 4'd0, 2'd0, 4'd0, 32'd3, OVH_SEVERE), 0);
		// Highest valid indexes, with the time wrapping between the two taps.
		send_tap(tap_req(16'd10000, 16'hFFFF, 2'd3, 4'd9, 2'd3, 4'd9, 32'hFFFF_FFF0,
			OVH_MILD), 0);
		send_tap(tap_req(16'd10000, 16'd100, 2'd3, 4'd9, 2'd3, 4'd9, 32'h0000_0010,
			OVH_MODERATE), 0);
		send_tap(tap_req(16'd5000, 16'd7, 2'd1, 4'd5, 2'd2, 4'd6, 32'd500, OVH_HIGH), 0);
		send_tap(tap_req(16'd5000, 16'd7, 2'd1, 4'd5, 2'd2, 4'd6, 32'd600, OVH_SEVERE), 0);
		send_tap(tap_req(16'd5000, 16'd7, 2'd1, 4'd5, 2'd2, 4'd6, 32'd700, 3'd5), 0);
		send_tap(tap_req(16'd5000, 16'd7, 2'd1, 4'd5, 2'd2, 4'd6, 32'd800, 3'd7), 0);
		// Empty taps with pins out of range, all clamped; then a small driven tap.
		send_tap(tap_req(16'd20000, 16'd50, 2'd0, 4'd10, 2'd0, 4'd0, 32'd100, 3'd0), 0);
		send_tap(tap_req(16'hFFFF, 16'd50, 2'd0, 4'd1, 2'd2, 4'd15, 32'd100, OVH_MILD), 0);
		send_tap(tap_req(16'hFFFF, 16'hFFFF, 2'h3, 4'hF, 2'h3, 4'hF, 32'hFFFF_FFFF, 3'h7), 0);
		send_tap(tap_req(16'd1, 16'd0, 2'd2, 4'd0, 2'd1, 4'd0, 32'd1000, OVH_SEVERE), 0);
		drain_taps();

		// Random taps over a series of settings, extremes included.
		apply_setting(20'd655350, 3'd4, 16'd10, 24'd20000, 16'd4, 1'b1);
		run_random(220);
		apply_setting(20'hFFFFF, 3'd3, 16'd1, 24'd0, 16'd1, 1'b1);
		run_random(220);
		apply_setting(20'd50000, 3'd2, 16'hFFFF, 24'hFFFFFF, 16'hFFFF, 1'b1);
		run_random(220);
		apply_setting(20'd80000, 3'd1, 16'd0, 24'd500, 16'd0, 1'b1);
		run_random(220);
		apply_setting(20'd100000, 3'd4, 16'd100, 24'd50000, 16'd10, 1'b0);
		run_random(220);
		apply_setting(20'd300000, 3'd7, 16'd1000, 24'd100000, 16'd2, 1'b1);
		run_random(220);
		apply_setting(20'd0, 3'd0, 16'd5, 24'd1000, 16'd3, 1'b1);
		run_random(60);
		apply_setting(20'd655350, 3'd4, 16'hFFFF, 24'd0, 16'hFFFF, 1'b1);
		run_random(220);

		// Everything is back; leave room for any stray result beat.
		repeat (60) @(posedge clk);
		if (fail_count == 0 && pending == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10_000_000;
		$display("*** FAILED ***");
		$finish;
	end

endmodule

// ----- sim.f -----
design/tdl_pkg.sv
design/tdl_ram.sv
design/tap_thermal_duration_limiter.sv
tb/tap_result_checker.sv
tb/testbench.sv
